// ===== rtl/uil_pkg.sv =====
package uil_pkg;

	localparam int unsigned GAP_RESET  = 300;
	localparam int unsigned FRAG_RESET = 300;
	localparam int unsigned MODE_RATIO = 2;
	localparam int unsigned CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SEQ_LENGTH     = 2'd0,
		REG_COVERED_LENGTH = 2'd1,
		REG_MIN_GAP        = 2'd2,
		REG_MIN_FRAG       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic mode_b;
		logic close;
	} uil_ctl_t;

endpackage

// ===== rtl/uil_track.sv =====
module uil_track #(
	parameter int POS_BITS = 30,
	parameter int LIM_W    = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_is_end,
	input  logic [POS_BITS-1:0]   in_pos,
	input  logic                  in_last,
	input  logic                  mode_b,
	input  logic [POS_BITS-1:0]   seq_length,
	input  logic [LIM_W-1:0]      min_gap,
	input  logic [LIM_W-1:0]      min_frag,
	input  logic                  down_ready,
	output uil_pkg::uil_ctl_t     ctl_s2,
	output logic [POS_BITS-1:0]   add1_s2,
	output logic [POS_BITS-1:0]   open_s2,
	output logic [POS_BITS-1:0]   end_s2
);

	logic                valid_s1;
	logic                is_end_s1;
	logic                last_s1;
	logic [POS_BITS-1:0] pos_s1;

	logic [POS_BITS-1:0] pair_start_q;
	logic [POS_BITS-1:0] open_start_q;
	logic [POS_BITS-1:0] prev_end_q;
	logic                first_seen_q;
	logic                have_open_q;

	logic                adv_s2;
	logic                fire;
	logic                span_ok;
	logic                keep;
	logic                gap_brk;
	logic                ok1;
	logic [POS_BITS-1:0] len1;
	logic [POS_BITS-1:0] add1_n;
	logic [POS_BITS-1:0] open_n;
	logic [POS_BITS-1:0] prev_n;
	logic [POS_BITS-1:0] end_n;
	logic                have_n;

	assign adv_s2   = !ctl_s2.valid || down_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign fire     = valid_s1 && adv_s2;

	always_comb begin
		span_ok = (pos_s1 > pair_start_q)
			&& (LIM_W'(pos_s1 - pair_start_q) > min_frag);
		keep    = is_end_s1 && first_seen_q && (!mode_b || span_ok);
		gap_brk = have_open_q && (pair_start_q > prev_end_q)
			&& (LIM_W'(pair_start_q - prev_end_q) > min_gap);
		len1    = prev_end_q - open_start_q;
		ok1     = (prev_end_q > open_start_q) && (mode_b || LIM_W'(len1) > min_frag);
		add1_n  = (keep && gap_brk && ok1) ? len1 : '0;

		open_n = open_start_q;
		have_n = have_open_q;
		prev_n = prev_end_q;
		if (keep) begin
			if (!have_open_q) begin
				open_n = (LIM_W'(pair_start_q) < min_gap) ? '0 : pair_start_q;
				have_n = 1'b1;
			end else if (gap_brk) begin
				open_n = pair_start_q;
			end
			prev_n = pos_s1;
		end

		// final end snaps to the sequence length
		if ((prev_n > seq_length) || (LIM_W'(seq_length - prev_n) < min_gap)) begin
			end_n = seq_length;
		end else begin
			end_n = prev_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			is_end_s1 <= in_is_end;
			pos_s1    <= in_pos;
			last_s1   <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_start_q <= '0;
			open_start_q <= '0;
			prev_end_q   <= '0;
			first_seen_q <= 1'b0;
			have_open_q  <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				pair_start_q <= '0;
				open_start_q <= '0;
				prev_end_q   <= '0;
				first_seen_q <= 1'b0;
				have_open_q  <= 1'b0;
			end else begin
				if (!is_end_s1) begin
					pair_start_q <= pos_s1;
				end
				first_seen_q <= !is_end_s1;
				open_start_q <= open_n;
				prev_end_q   <= prev_n;
				have_open_q  <= have_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv_s2) begin
			ctl_s2.valid  <= valid_s1;
			ctl_s2.last   <= last_s1;
			ctl_s2.mode_b <= mode_b;
			ctl_s2.close  <= last_s1 && have_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			add1_s2 <= add1_n;
			open_s2 <= open_n;
			end_s2  <= end_n;
		end
	end

endmodule

// ===== rtl/uil_close.sv =====
module uil_close #(
	parameter int POS_BITS = 30,
	parameter int LIM_W    = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uil_pkg::uil_ctl_t     ctl_s2,
	input  logic [POS_BITS-1:0]   add1_s2,
	input  logic [POS_BITS-1:0]   open_s2,
	input  logic [POS_BITS-1:0]   end_s2,
	input  logic [LIM_W-1:0]      min_frag,
	output logic                  up_ready,
	input  logic                  down_ready,
	output uil_pkg::uil_ctl_t     ctl_s3,
	output logic [POS_BITS-1:0]   add1_s3,
	output logic [POS_BITS-1:0]   add2_s3
);

	logic [POS_BITS-1:0] len2;
	logic                ok2;
	logic [POS_BITS-1:0] add2_n;

	assign up_ready = !ctl_s3.valid || down_ready;

	// length of the fragment closed by the last marker
	always_comb begin
		len2   = end_s2 - open_s2;
		ok2    = ctl_s2.close && (end_s2 > open_s2)
			&& (ctl_s2.mode_b || LIM_W'(len2) > min_frag);
		add2_n = ok2 ? len2 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (up_ready) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && ctl_s2.valid) begin
			add1_s3 <= add1_s2;
			add2_s3 <= add2_n;
		end
	end

endmodule

// ===== rtl/uil_accum.sv =====
module uil_accum #(
	parameter int POS_BITS = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uil_pkg::uil_ctl_t     ctl_s3,
	input  logic [POS_BITS-1:0]   add1_s3,
	input  logic [POS_BITS-1:0]   add2_s3,
	output logic                  up_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_BITS-1:0]   total_length
);

	localparam int SUM_W = POS_BITS + 2;

	logic [POS_BITS-1:0] total_q;
	logic [SUM_W-1:0]    sum;
	logic [POS_BITS-1:0] sat;
	logic                take;

	assign up_ready = !out_valid || out_ready || !ctl_s3.last;
	assign take     = ctl_s3.valid && up_ready;

	always_comb begin
		sum = SUM_W'(total_q) + SUM_W'(add1_s3) + SUM_W'(add2_s3);
		sat = (sum > SUM_W'({POS_BITS{1'b1}})) ? {POS_BITS{1'b1}} : sum[POS_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				total_q <= ctl_s3.last ? '0 : sat;
			end
			if (take && ctl_s3.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctl_s3.last) begin
			total_length <= sat;
		end
	end

endmodule

// ===== rtl/unique_interval_length_unit.sv =====
// result: a last marker passes the s1, s2 and s3 registers before its total is registered on m_axis
// throughput: one marker per cycle; a result waiting on m_axis stalls the
//   pipeline only when a second result reaches the output stage
// reset: arst_n clears the pipeline, the list state and the running sum, and
//   loads the register defaults (min_gap and min_frag 300, others 0)
module unique_interval_length_unit #(
	parameter int POS_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((POS_BITS+7)/8)*8-1:0]        s_axis_tdata,  // position
	input  logic                                 s_axis_tuser,  // is_end
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((POS_BITS+7)/8)*8-1:0]        m_axis_tdata,  // total_length
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [uil_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [POS_BITS-1:0]                  cfg_data
);

	localparam int DATA_W = ((POS_BITS + 7) / 8) * 8;
	localparam int RST_W  = $clog2(((uil_pkg::GAP_RESET > uil_pkg::FRAG_RESET) ?
		uil_pkg::GAP_RESET : uil_pkg::FRAG_RESET) + 1);
	localparam int LIM_W  = (POS_BITS > RST_W) ? POS_BITS : RST_W;

	logic [POS_BITS-1:0] seq_length_q;
	logic [POS_BITS-1:0] covered_length_q;
	logic [LIM_W-1:0]    min_gap_q;
	logic [LIM_W-1:0]    min_frag_q;
	logic                mode_b;

	uil_pkg::uil_ctl_t   ctl_s2;
	uil_pkg::uil_ctl_t   ctl_s3;
	logic [POS_BITS-1:0] add1_s2;
	logic [POS_BITS-1:0] open_s2;
	logic [POS_BITS-1:0] end_s2;
	logic [POS_BITS-1:0] add1_s3;
	logic [POS_BITS-1:0] add2_s3;
	logic                ready_s3;
	logic                ready_acc;
	logic [POS_BITS-1:0] total_length;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q     <= '0;
			covered_length_q <= '0;
			min_gap_q        <= LIM_W'(uil_pkg::GAP_RESET);
			min_frag_q       <= LIM_W'(uil_pkg::FRAG_RESET);
		end else if (cfg_valid) begin
			unique case (uil_pkg::cfg_reg_t'(cfg_index))
				uil_pkg::REG_SEQ_LENGTH:     seq_length_q     <= cfg_data;
				uil_pkg::REG_COVERED_LENGTH: covered_length_q <= cfg_data;
				uil_pkg::REG_MIN_GAP:        min_gap_q        <= LIM_W'(cfg_data);
				uil_pkg::REG_MIN_FRAG:       min_frag_q       <= LIM_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// filter-first when the sequence is shorter than twice the covered length, or shorter than 2 when it is 0
	always_comb begin
		if (covered_length_q == '0) begin
			mode_b = {1'b0, seq_length_q} < (POS_BITS+1)'(uil_pkg::MODE_RATIO);
		end else begin
			mode_b = {1'b0, seq_length_q} <
				((POS_BITS+1)'(covered_length_q) * (POS_BITS+1)'(uil_pkg::MODE_RATIO));
		end
	end

	uil_track #(
		.POS_BITS (POS_BITS),
		.LIM_W    (LIM_W)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_is_end  (s_axis_tuser),
		.in_pos     (s_axis_tdata[POS_BITS-1:0]),
		.in_last    (s_axis_tlast),
		.mode_b     (mode_b),
		.seq_length (seq_length_q),
		.min_gap    (min_gap_q),
		.min_frag   (min_frag_q),
		.down_ready (ready_s3),
		.ctl_s2     (ctl_s2),
		.add1_s2    (add1_s2),
		.open_s2    (open_s2),
		.end_s2     (end_s2)
	);

	uil_close #(
		.POS_BITS (POS_BITS),
		.LIM_W    (LIM_W)
	) u_close (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s2     (ctl_s2),
		.add1_s2    (add1_s2),
		.open_s2    (open_s2),
		.end_s2     (end_s2),
		.min_frag   (min_frag_q),
		.up_ready   (ready_s3),
		.down_ready (ready_acc),
		.ctl_s3     (ctl_s3),
		.add1_s3    (add1_s3),
		.add2_s3    (add2_s3)
	);

	uil_accum #(
		.POS_BITS (POS_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s3       (ctl_s3),
		.add1_s3      (add1_s3),
		.add2_s3      (add2_s3),
		.up_ready     (ready_acc),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.total_length (total_length)
	);

	assign m_axis_tdata = DATA_W'(total_length);

endmodule

// ===== rtl/uil_checker.sv =====
module uil_checker #(
	parameter int DATA_W = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              s_axis_tlast,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata
);

	logic [2:0] pending_q;
	logic       in_last_xfer;
	logic       out_xfer;

	assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_xfer     = m_axis_tvalid && m_axis_tready;

	// lists closed on the input side whose result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_last_xfer) - 3'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> !m_axis_tvalid)
		else $error("result without a closed list");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more closed lists in flight than pipeline stages");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with a free output");

endmodule

bind unique_interval_length_unit uil_checker #(
	.DATA_W (((POS_BITS + 7) / 8) * 8)
) u_uil_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/uil_total_checker.sv =====
module uil_total_checker #(
	parameter int POS_BITS = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [((POS_BITS+7)/8)*8-1:0]   s_axis_tdata,  // position
	input  logic                            s_axis_tuser,  // is_end
	input  logic                            s_axis_tlast,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [((POS_BITS+7)/8)*8-1:0]   m_axis_tdata,  // total_length
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [uil_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [POS_BITS-1:0]             cfg_data,
	output int                              mismatches,
	output int                              totals_pending
);

	localparam int DW = ((POS_BITS+7)/8)*8;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam int REPORT_LIMIT = 10;

	typedef logic [POS_BITS-1:0] pos_t;

	pos_t seq_length;
	pos_t covered_length;
	pos_t min_gap;
	pos_t min_frag;

	pos_t frag_start;
	pos_t merge_end;
	pos_t pend_start;
	pos_t total;
	logic frag_open;
	logic pend_valid;

	pos_t expected_totals[$];
	int fail_total;

	function automatic logic filter_first_mode();
		if (covered_length == '0)
			return longint'(seq_length) < longint'(uil_pkg::MODE_RATIO);
		return longint'(seq_length) < longint'(uil_pkg::MODE_RATIO) * longint'(covered_length);
	endfunction

	task automatic clear_list();
		frag_start = '0;
		merge_end = '0;
		pend_start = '0;
		total = '0;
		frag_open = 1'b0;
		pend_valid = 1'b0;
	endtask

	task automatic close_frag(input pos_t end_pos, input logic filt);
		longint unsigned len;
		longint unsigned acc;
		if (frag_open && end_pos > frag_start) begin
			len = end_pos - frag_start;
			if (filt || len > min_frag) begin
				acc = total + len;
				total = (acc > POS_MAX) ? POS_MAX : pos_t'(acc);
			end
		end
		frag_open = 1'b0;
	endtask

	task automatic apply_marker(input logic is_end, input pos_t pos, input logic last);
		logic filt;
		logic keep;
		pos_t end_pos;
		filt = filter_first_mode();
		if (!is_end) begin
			pend_start = pos;
			pend_valid = 1'b1;
		end else if (pend_valid) begin
			keep = !filt || (pos > pend_start && (pos - pend_start) > min_frag);
			pend_valid = 1'b0;
			if (keep) begin
				if (!frag_open) begin
					frag_start = (pend_start < min_gap) ? '0 : pend_start;
					frag_open = 1'b1;
				end else if (pend_start > merge_end && (pend_start - merge_end) > min_gap) begin
					close_frag(merge_end, filt);
					frag_start = pend_start;
					frag_open = 1'b1;
				end
				merge_end = pos;
			end
		end
		if (last) begin
			if (frag_open) begin
				end_pos = merge_end;
				// final end snaps to the sequence length
				if (end_pos > seq_length || (seq_length - end_pos) < min_gap)
					end_pos = seq_length;
				close_frag(end_pos, filt);
			end
			expected_totals.insert(expected_totals.size(), total);
			clear_list();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length = '0;
			covered_length = '0;
			min_gap = pos_t'(uil_pkg::GAP_RESET);
			min_frag = pos_t'(uil_pkg::FRAG_RESET);
			clear_list();
			expected_totals.delete();
			fail_total = 0;
			mismatches <= 0;
			totals_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					uil_pkg::REG_SEQ_LENGTH:     seq_length = cfg_data;
					uil_pkg::REG_COVERED_LENGTH: covered_length = cfg_data;
					uil_pkg::REG_MIN_GAP:        min_gap = cfg_data;
					uil_pkg::REG_MIN_FRAG:       min_frag = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_totals.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("unexpected total_length transfer: got %0d", m_axis_tdata);
				end else if (m_axis_tdata != DW'(expected_totals[0])) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("total_length mismatch: expected %0d got %0d",
							expected_totals[0], m_axis_tdata);
					void'(expected_totals.pop_front());
				end else begin
					void'(expected_totals.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_marker(s_axis_tuser, s_axis_tdata[POS_BITS-1:0], s_axis_tlast);
			mismatches <= fail_total;
			totals_pending <= expected_totals.size();
		end
	end

endmodule

// ===== verif/tb_unique_interval_length_unit.sv =====
module tb_unique_interval_length_unit;

	localparam int POS_BITS = 30;
	localparam int DW = ((POS_BITS+7)/8)*8;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam int LATENCY_WAIT = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 850;
	localparam int PHASE_ITEMS = 80;
	localparam logic MARK_START = 1'b0;
	localparam logic MARK_END = 1'b1;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DW-1:0] s_axis_tdata = '0;   // position
	logic s_axis_tuser = 1'b0;          // is_end
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DW-1:0] m_axis_tdata;        // total_length
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [uil_pkg::CFG_INDEX_W-1:0] cfg_index = uil_pkg::REG_SEQ_LENGTH;
	logic [POS_BITS-1:0] cfg_data = '0;

	int mismatches;
	int totals_pending;
	int cycles = 0;
	int markers_sent = 0;
	int burst_left = 0;
	int stall_left = 0;
	rx_mode_t stall_mode = RX_OPEN;

	pos_t cur_seq = '0;
	pos_t cur_gap = pos_t'(uil_pkg::GAP_RESET);
	pos_t cur_frag = pos_t'(uil_pkg::FRAG_RESET);

	unique_interval_length_unit #(
		.POS_BITS(POS_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	uil_total_checker #(
		.POS_BITS(POS_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.totals_pending(totals_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side stalls on its own changing pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			RX_OPEN:     m_axis_tready <= 1'b1;
			RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: m_axis_tready <= ((cycles % 11) < 4);
			default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	function automatic pos_t clamp_pos(input longint unsigned v);
		return (v > POS_MAX) ? POS_MAX : pos_t'(v);
	endfunction

	// distance around a threshold, both sides of it
	function automatic longint unsigned near(input pos_t thr);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom_range(0, thr);
			2: return thr;
			3: return longint'(thr) + 1;
			4: return longint'(thr) + $urandom_range(1, 2000);
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	task automatic send_marker(input logic is_end, input pos_t pos, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DW'(pos);
		s_axis_tuser <= is_end;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		markers_sent++;
	endtask

	// hold off until every total has come out and the pipeline has emptied
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (totals_pending != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic load_config(input pos_t seq, input pos_t cov, input pos_t gap,
		input pos_t frag);
		pos_t vals[4];
		uil_pkg::cfg_reg_t regs[4];
		vals = '{seq, cov, gap, frag};
		regs = '{uil_pkg::REG_SEQ_LENGTH, uil_pkg::REG_COVERED_LENGTH,
			uil_pkg::REG_MIN_GAP, uil_pkg::REG_MIN_FRAG};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_seq = seq;
		cur_gap = gap;
		cur_frag = frag;
	endtask

	// alternating list, rising but for the last end; gaps and lengths spread around the thresholds
	task automatic send_region_list();
		int n;
		longint unsigned cursor;
		longint unsigned start_p;
		longint unsigned end_p;
		longint unsigned nv;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
		cursor = near(cur_gap);
		for (int i = 0; i < n; i++) begin
			start_p = (i == 0) ? cursor : cursor + near(cur_gap);
			end_p = clamp_pos(start_p) + near(cur_frag);
			if (i == n - 1) begin
				case ($urandom_range(0, 3))
					0: begin
						nv = near(cur_gap);
						if (longint'(cur_seq) >= nv)
							end_p = cur_seq - nv;
					end
					1: end_p = longint'(cur_seq) + $urandom_range(0, 50);
					default: ;
				endcase
			end
			send_marker(MARK_START, clamp_pos(start_p), 1'b0);
			send_marker(MARK_END, clamp_pos(end_p), i == n - 1);
			cursor = clamp_pos(end_p);
		end
	endtask

	task automatic send_noise_list();
		int n;
		pos_t pos;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			pos = ($urandom_range(0, 1) != 0) ? pos_t'($urandom_range(0, POS_MAX))
				: pos_t'($urandom_range(0, 5000));
			send_marker($urandom_range(0, 1) != 0, pos, i == n - 1);
		end
	endtask

	initial begin
		int phase;
		int target;
		int phase_end;
		pos_t rc;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_config(10000, 1000, 300, 300);
		// merging, dropping a short fragment, both end snaps
		send_marker(MARK_START, 100, 1'b0);
		send_marker(MARK_END, 1000, 1'b0);
		send_marker(MARK_START, 1200, 1'b0);
		send_marker(MARK_END, 2000, 1'b0);
		send_marker(MARK_START, 2400, 1'b0);
		send_marker(MARK_END, 2600, 1'b0);
		send_marker(MARK_START, 9800, 1'b0);
		send_marker(MARK_END, 9900, 1'b1);
		// start after start, then last on a start
		send_marker(MARK_START, 500, 1'b0);
		send_marker(MARK_START, 700, 1'b0);
		send_marker(MARK_END, 2000, 1'b0);
		send_marker(MARK_START, 3000, 1'b1);
		// start before previous end, smaller newest end
		send_marker(MARK_START, 400, 1'b0);
		send_marker(MARK_END, 5000, 1'b0);
		send_marker(MARK_START, 1000, 1'b0);
		send_marker(MARK_END, 2000, 1'b1);
		// reversed fragment
		send_marker(MARK_START, 5000, 1'b0);
		send_marker(MARK_END, 4000, 1'b1);
		// lone end carrying last
		send_marker(MARK_END, 0, 1'b1);
		// mode switches to filter-first in the middle of a list
		send_marker(MARK_START, 1000, 1'b0);
		send_marker(MARK_END, 5000, 1'b0);
		wait_idle();
		load_config(10000, 8000, 300, 300);
		send_marker(MARK_START, 6000, 1'b0);
		send_marker(MARK_END, 6100, 1'b1);
		// field extremes
		wait_idle();
		load_config(POS_MAX, 0, POS_MAX, 0);
		send_marker(MARK_START, 0, 1'b0);
		send_marker(MARK_END, POS_MAX, 1'b1);

		target = markers_sent + RANDOM_ITEMS;
		phase = 0;
		while (markers_sent < target) begin
			wait_idle();
			case (phase)
				0: load_config(100000, 20000, 300, 300);
				1: load_config(100000, 60000, 300, 300);
				2: load_config(POS_MAX, POS_MAX, 0, 0);
				3: load_config(POS_MAX, 0, POS_MAX, POS_MAX);
				4: load_config(1, 0, 0, POS_MAX);
				5: load_config(40000, 20000, 500, 100);
				6: load_config(39999, 20000, 500, 100);
				7: load_config(0, 0, 300, 300);
				default: begin
					rc = ($urandom_range(0, 3) == 0) ? pos_t'(0)
						: pos_t'($urandom_range(0, 120000));
					load_config(pos_t'($urandom_range(0, 200000)), rc,
						pos_t'($urandom_range(0, 1000)), pos_t'($urandom_range(0, 1000)));
				end
			endcase
			phase_end = markers_sent + PHASE_ITEMS;
			while (markers_sent < phase_end && markers_sent < target) begin
				if ($urandom_range(0, 3) != 0)
					send_region_list();
				else
					send_noise_list();
			end
			phase++;
		end

		wait_idle();
		if (mismatches == 0 && totals_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
